// ===== rtl/core/dsa_pkg.sv =====
// Shared types and constants for the scan acquisition sequencer.
// No dependencies; used by the sequencer top level in rtl/core.
`default_nettype none

package dsa_pkg;

	localparam int MAX_CHANNELS_DEF  = 16;
	localparam int READING_WIDTH_DEF = 48;
	localparam int CHANNEL_W         = 7;
	localparam int SLOT_W            = 4;
	localparam int COUNT_W           = 5;
	localparam int LIMIT_W           = 32;
	localparam int CFG_DATA_W        = 32;
	localparam int SYNC_W            = 4;
	localparam logic [SYNC_W-1:0] SYNC_LAST = 4'd9;

	typedef enum logic [1:0] {
		FUNC_RESP  = 2'd0,
		FUNC_LOAD  = 2'd1,
		FUNC_START = 2'd2
	} func_t;

	typedef enum logic [2:0] {
		CMD_NONE  = 3'd0,
		CMD_TRIG  = 3'd1,
		CMD_HIRES = 3'd2,
		CMD_RANGE = 3'd3,
		CMD_CHAN  = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		FAULT_NONE     = 2'd0,
		FAULT_CHAN_RD  = 2'd1,
		FAULT_CHAN_SYN = 2'd2,
		FAULT_UNEXP    = 2'd3
	} fault_t;

	typedef enum logic [1:0] {
		CFG_HIRES = 2'd0,
		CFG_LIMIT = 2'd1,
		CFG_COUNT = 2'd2
	} cfg_idx_t;

	typedef enum logic [2:0] {
		PH_IDLE  = 3'd0,
		PH_TRIG  = 3'd1,
		PH_HIRES = 3'd2,
		PH_RANGE = 3'd3,
		PH_CHAN  = 3'd4
	} phase_t;

endpackage

`default_nettype wire

// ===== rtl/core/dsa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies. Read during write to the same address returns old data.
`default_nettype none

module dsa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ===== rtl/core/dsa_obuf.sv =====
// Output register with skid stage for the result stream.
// No package dependencies; used by the sequencer top level.
`default_nettype none

module dsa_obuf #(
	parameter int W = 8
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_ready,
	input  wire logic [W-1:0] in_data,
	output logic              out_valid,
	input  wire logic         out_ready,
	output logic      [W-1:0] out_data
);

	logic         out_valid_q;
	logic         skid_valid_q;
	logic [W-1:0] out_data_q;
	logic [W-1:0] skid_data_q;

	assign in_ready  = !skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || out_ready) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= in_valid;
			end
		end else if (in_valid && in_ready) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || out_ready) begin
			out_data_q <= skid_valid_q ? skid_data_q : in_data;
		end else if (in_valid && in_ready) begin
			skid_data_q <= in_data;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/dmm_scan_acquisition_sequencer.sv =====
// Scan acquisition sequencer: instrument query/response loop and reading output.
// Depends on dsa_pkg, dsa_ram (scan list) and dsa_obuf (result register).
`default_nettype none

// One request is taken every cycle and each gives exactly one result, held in
// the output or skid register; s_tready only drops while the skid stage holds
// a result that the downstream side has not taken. The scan list sits in a RAM
// with a registered read; its read address tracks the next scan position, so
// the current channel is ready when the next response arrives, and a load that
// hits that entry is forwarded for one cycle. Configuration may be written only
// while no request is in flight. There is no clearing pass after reset.

module dmm_scan_acquisition_sequencer #(
	parameter int MAX_CHANNELS  = dsa_pkg::MAX_CHANNELS_DEF,
	parameter int READING_WIDTH = dsa_pkg::READING_WIDTH_DEF,
	localparam int RW = READING_WIDTH,
	localparam int ID = RW + 1 + dsa_pkg::SLOT_W + dsa_pkg::CHANNEL_W,
	localparam int IW = ((ID + 7) / 8) * 8,
	localparam int OD = 3 + 1 + (RW + 1) + dsa_pkg::CHANNEL_W + 2,
	localparam int OW = ((OD + 7) / 8) * 8
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	// response_ok, response_value, list_slot, channel_number
	input  wire logic [IW-1:0]                   s_tdata,
	// func
	input  wire logic [1:0]                      s_tuser,
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	// command, reading_valid, reading, reading_channel, fault
	output logic      [OW-1:0]                   m_tdata,
	// stop
	output logic                                 m_tlast,
	input  wire logic                            cfg_we,
	input  wire logic [1:0]                      cfg_index,
	input  wire logic [dsa_pkg::CFG_DATA_W-1:0]  cfg_data
);

	localparam int CW = dsa_pkg::CHANNEL_W;
	localparam int PW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int EW = ($clog2(MAX_CHANNELS + 1) > dsa_pkg::COUNT_W) ?
		$clog2(MAX_CHANNELS + 1) : dsa_pkg::COUNT_W;
	localparam int LW = dsa_pkg::LIMIT_W;
	localparam int SW = dsa_pkg::SYNC_W;

	// input fields
	logic                      in_ok;
	logic [RW-1:0]             in_val;
	logic [dsa_pkg::SLOT_W-1:0] in_slot;
	logic [CW-1:0]             in_chn;
	logic                      accept;

	assign in_ok   = s_tdata[0];
	assign in_val  = s_tdata[RW:1];
	assign in_slot = s_tdata[RW+dsa_pkg::SLOT_W:RW+1];
	assign in_chn  = s_tdata[ID-1:RW+dsa_pkg::SLOT_W+1];
	assign accept  = s_tvalid && s_tready;

	// configuration
	logic                         hires_en_q;
	logic [LW-1:0]                limit_q;
	logic [dsa_pkg::COUNT_W-1:0]  ccount_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hires_en_q <= 1'b0;
			limit_q    <= '0;
			ccount_q   <= dsa_pkg::COUNT_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				dsa_pkg::CFG_HIRES: hires_en_q <= cfg_data[0];
				dsa_pkg::CFG_LIMIT: limit_q    <= cfg_data[LW-1:0];
				dsa_pkg::CFG_COUNT: ccount_q   <= cfg_data[dsa_pkg::COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	// state
	dsa_pkg::phase_t phase_q, phase_d;
	logic [RW-1:0]   base_q, base_d;
	logic [RW-1:0]   hires_q, hires_d;
	logic [LW-1:0]   cnt_q, cnt_d;
	logic [SW-1:0]   sync_q, sync_d;
	logic [PW-1:0]   pos_q, pos_d;

	// scan list
	logic            ram_we;
	logic [EW-1:0]   slot_ext;
	logic [CW-1:0]   ram_rdata;
	logic            fwd_hit_q;
	logic [CW-1:0]   fwd_data_q;
	logic [CW-1:0]   cur_chn;

	assign slot_ext = EW'(in_slot);
	assign cur_chn  = fwd_hit_q ? fwd_data_q : ram_rdata;

	dsa_ram #(
		.WIDTH (CW),
		.DEPTH (MAX_CHANNELS)
	) u_scan_list (
		.clk   (clk),
		.we    (ram_we),
		.waddr (slot_ext[PW-1:0]),
		.wdata (in_chn),
		.raddr (pos_d),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_hit_q <= 1'b0;
		end else begin
			fwd_hit_q <= ram_we && (slot_ext[PW-1:0] == pos_d);
		end
	end

	always_ff @(posedge clk) begin
		fwd_data_q <= in_chn;
	end

	// derived values
	logic [EW-1:0]   eff_cnt;
	logic [EW-1:0]   pos_inc;
	logic [LW-1:0]   cnt_inc;
	logic [SW-1:0]   sync_inc;
	logic            hit_cur;
	logic            hit_inc;
	logic [RW:0]     sum;

	always_comb begin
		eff_cnt = EW'(ccount_q);
		if (eff_cnt == '0) begin
			eff_cnt = EW'(1);
		end
		if (eff_cnt > EW'(MAX_CHANNELS)) begin
			eff_cnt = EW'(MAX_CHANNELS);
		end
	end

	assign pos_inc  = EW'(pos_q) + EW'(1);
	assign cnt_inc  = cnt_q + LW'(1);
	assign sync_inc = (sync_q >= dsa_pkg::SYNC_LAST) ? '0 : sync_q + SW'(1);
	assign hit_cur  = (limit_q != '0) && (cnt_q >= limit_q);
	assign hit_inc  = (limit_q != '0) && (cnt_inc >= limit_q);
	assign sum      = {base_q[RW-1], base_q} +
		(hires_en_q ? {hires_q[RW-1], hires_q} : '0);

	// result fields
	dsa_pkg::cmd_t   cmd;
	dsa_pkg::fault_t fault;
	logic            rvalid;
	logic [RW:0]     rd;
	logic [CW-1:0]   rch;
	logic            stop;
	logic            check;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= dsa_pkg::PH_IDLE;
		end else begin
			phase_q <= phase_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q  <= '0;
			hires_q <= '0;
			cnt_q   <= '0;
			sync_q  <= '0;
			pos_q   <= '0;
		end else begin
			base_q  <= base_d;
			hires_q <= hires_d;
			cnt_q   <= cnt_d;
			sync_q  <= sync_d;
			pos_q   <= pos_d;
		end
	end

	always_comb begin
		phase_d = phase_q;
		base_d  = base_q;
		hires_d = hires_q;
		cnt_d   = cnt_q;
		sync_d  = sync_q;
		pos_d   = pos_q;
		cmd     = dsa_pkg::CMD_NONE;
		fault   = dsa_pkg::FAULT_NONE;
		rvalid  = 1'b0;
		rd      = '0;
		rch     = '0;
		stop    = 1'b0;
		check   = 1'b0;
		ram_we  = 1'b0;
		if (accept) begin
			case (s_tuser)
				dsa_pkg::FUNC_LOAD: begin
					ram_we = slot_ext < EW'(MAX_CHANNELS);
				end
				dsa_pkg::FUNC_START: begin
					cnt_d   = '0;
					sync_d  = '0;
					pos_d   = '0;
					phase_d = dsa_pkg::PH_TRIG;
					cmd     = dsa_pkg::CMD_TRIG;
				end
				dsa_pkg::FUNC_RESP: begin
					case (phase_q)
						dsa_pkg::PH_TRIG: begin
							if (!in_ok) begin
								cmd = dsa_pkg::CMD_TRIG;
							end else begin
								base_d = in_val;
								check  = 1'b1;
								if (hires_en_q) begin
									cmd     = dsa_pkg::CMD_HIRES;
									phase_d = dsa_pkg::PH_HIRES;
								end else begin
									cmd     = dsa_pkg::CMD_RANGE;
									phase_d = dsa_pkg::PH_RANGE;
								end
							end
						end
						dsa_pkg::PH_HIRES: begin
							if (!in_ok) begin
								cmd     = dsa_pkg::CMD_TRIG;
								phase_d = dsa_pkg::PH_TRIG;
							end else begin
								hires_d = in_val;
								cmd     = dsa_pkg::CMD_RANGE;
								phase_d = dsa_pkg::PH_RANGE;
								check   = 1'b1;
							end
						end
						dsa_pkg::PH_RANGE: begin
							if (!in_ok) begin
								cmd     = dsa_pkg::CMD_TRIG;
								phase_d = dsa_pkg::PH_TRIG;
							end else begin
								rvalid = 1'b1;
								rd     = sum;
								rch    = cur_chn;
								cnt_d  = cnt_inc;
								sync_d = sync_inc;
								if (hit_inc) begin
									stop    = 1'b1;
									phase_d = dsa_pkg::PH_IDLE;
								end else begin
									pos_d = (pos_inc >= eff_cnt) ? '0 : pos_inc[PW-1:0];
									if (sync_inc == dsa_pkg::SYNC_LAST && eff_cnt > EW'(1)) begin
										cmd     = dsa_pkg::CMD_CHAN;
										phase_d = dsa_pkg::PH_CHAN;
									end else begin
										cmd     = dsa_pkg::CMD_TRIG;
										phase_d = dsa_pkg::PH_TRIG;
									end
								end
							end
						end
						dsa_pkg::PH_CHAN: begin
							if (!in_ok) begin
								stop    = 1'b1;
								fault   = dsa_pkg::FAULT_CHAN_RD;
								phase_d = dsa_pkg::PH_IDLE;
							end else if (in_val != RW'(cur_chn)) begin
								stop    = 1'b1;
								fault   = dsa_pkg::FAULT_CHAN_SYN;
								phase_d = dsa_pkg::PH_IDLE;
							end else begin
								cmd     = dsa_pkg::CMD_TRIG;
								phase_d = dsa_pkg::PH_TRIG;
								check   = 1'b1;
							end
						end
						default: begin
							fault = dsa_pkg::FAULT_UNEXP;
						end
					endcase
					if (check && hit_cur) begin
						stop    = 1'b1;
						phase_d = dsa_pkg::PH_IDLE;
					end
				end
				default: ;
			endcase
		end
	end

	// result register
	logic [OD:0]   res_word;
	logic [OD:0]   out_word;

	assign res_word = {stop, fault, rch, rd, rvalid, cmd};

	dsa_obuf #(
		.W (OD + 1)
	) u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (accept),
		.in_ready  (s_tready),
		.in_data   (res_word),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (out_word)
	);

	assign m_tdata = OW'(out_word[OD-1:0]);
	assign m_tlast = out_word[OD];

endmodule

`default_nettype wire
